// ===== design/htfd_pkg.sv =====
// shared constants and crc helper for the humidity/temperature frame decoder
package htfd_pkg;

    localparam int BYTE_W  = 8;
    localparam int WORD_W  = 16;
    localparam int POS_W   = 3;
    localparam int TEMP_W  = 17;
    localparam int HUMID_W = 15;
    localparam int ERR_W   = 2;

    localparam logic [BYTE_W-1:0] CRC_POLY = 8'h31;
    localparam logic [BYTE_W-1:0] CRC_INIT = 8'hFF;

    localparam logic [POS_W-1:0] POS_TEMP_HI  = 3'd0;
    localparam logic [POS_W-1:0] POS_TEMP_LO  = 3'd1;
    localparam logic [POS_W-1:0] POS_TEMP_CRC = 3'd2;
    localparam logic [POS_W-1:0] POS_HUM_HI   = 3'd3;
    localparam logic [POS_W-1:0] POS_HUM_LO   = 3'd4;
    localparam logic [POS_W-1:0] POS_HUM_CRC  = 3'd5;

    localparam logic [ERR_W-1:0] ERR_NONE  = 2'd0;
    localparam logic [ERR_W-1:0] ERR_TEMP  = 2'd1;
    localparam logic [ERR_W-1:0] ERR_HUMID = 2'd2;

    localparam logic [7:0] TEMP_SCALE  = 8'd175;
    localparam logic [6:0] HUMID_SCALE = 7'd100;

    localparam logic signed [17:0] TEMP_BASE_Q8 = 18'sd11520;
    localparam logic signed [17:0] TEMP_MAX_Q8  = 18'sd65535;
    localparam logic signed [17:0] TEMP_MIN_Q8  = -18'sd65536;

    localparam logic signed [WORD_W-1:0] TEMP_OFFSET_RESET = 16'sd1024;

    localparam logic [HUMID_W-1:0] HUMID_MAX_Q8 = 15'd25599;

    // crc-8, msb first, one byte
    function automatic logic [BYTE_W-1:0] crc8_add(input logic [BYTE_W-1:0] crc,
                                                   input logic [BYTE_W-1:0] data);
        logic [BYTE_W-1:0] c;
        c = crc ^ data;
        for (int i = 0; i < BYTE_W; i++) begin
            if (c[BYTE_W-1]) begin
                c = {c[BYTE_W-2:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[BYTE_W-2:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ===== design/humidity_temp_frame_decoder.sv =====
// humidity/temperature frame decoder: crc check and q8 conversion of a six-word frame
// the sixth word passes the input register, then the result register that drives m_valid
// throughput: one word per cycle (input and result registers) unless a result waits on m_ready
// a word that causes no result leaves the input register in the cycle after acceptance
// reset (aresetn low, synchronous): empties both registers, frame position to the
// first word, running crc to 0xff, temperature offset to 1024
module humidity_temp_frame_decoder
    import htfd_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,

    input  logic                      cfg_wr_en,
    input  logic signed [WORD_W-1:0]  cfg_wr_data,

    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [BYTE_W-1:0]         s_rx_byte,
    input  logic                      s_first_byte,

    output logic                      m_valid,
    input  logic                      m_ready,
    output logic                      m_read_ok,
    output logic [ERR_W-1:0]          m_error_code,
    output logic signed [TEMP_W-1:0]  m_temperature_q8,
    output logic [HUMID_W-1:0]        m_humidity_q8
);

    logic signed [WORD_W-1:0] offset_reg;

    logic                     in_valid_reg;
    logic [BYTE_W-1:0]        in_byte_reg;
    logic                     in_first_reg;

    logic [POS_W-1:0]         pos_reg, pos_next;
    logic [BYTE_W-1:0]        crc_reg, crc_next;
    logic [WORD_W-1:0]        temp_word_reg, temp_word_next;
    logic [WORD_W-1:0]        humid_word_reg, humid_word_next;
    logic                     temp_good_reg, temp_good_next;

    logic                     out_valid_reg;
    logic                     read_ok_reg, read_ok_next;
    logic [ERR_W-1:0]         err_reg, err_next;
    logic signed [TEMP_W-1:0] temp_q8_reg, temp_q8_next;
    logic [HUMID_W-1:0]       humid_q8_reg, humid_q8_next;

    logic                     advance;
    logic                     emit;
    logic [POS_W-1:0]         pos;
    logic [BYTE_W-1:0]        crc_base;
    logic [23:0]              temp_prod;
    logic [22:0]              humid_prod;
    logic signed [17:0]       temp_full;

    // a word goes out of the input register at once, but the sixth only when the result side can take it
    assign emit    = in_valid_reg && (pos == POS_HUM_CRC);
    assign advance = in_valid_reg && (!emit || !out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_comb begin
        pos = in_first_reg ? POS_TEMP_HI : pos_reg;
        if (pos > POS_HUM_CRC) begin
            pos = POS_TEMP_HI;
        end
    end

    always_comb begin
        crc_base        = ((pos == POS_TEMP_HI) || (pos == POS_HUM_HI)) ? CRC_INIT : crc_reg;
        crc_next        = crc_base;
        temp_word_next  = temp_word_reg;
        humid_word_next = humid_word_reg;
        temp_good_next  = temp_good_reg;
        pos_next        = pos + POS_W'(1);
        case (pos)
            POS_TEMP_HI: begin
                temp_word_next = {in_byte_reg, temp_word_reg[BYTE_W-1:0]};
                crc_next       = crc8_add(crc_base, in_byte_reg);
            end
            POS_TEMP_LO: begin
                temp_word_next = {temp_word_reg[WORD_W-1:BYTE_W], in_byte_reg};
                crc_next       = crc8_add(crc_base, in_byte_reg);
            end
            POS_TEMP_CRC: begin
                temp_good_next = (crc_reg == in_byte_reg);
                crc_next       = CRC_INIT;
            end
            POS_HUM_HI: begin
                humid_word_next = {in_byte_reg, humid_word_reg[BYTE_W-1:0]};
                crc_next        = crc8_add(crc_base, in_byte_reg);
            end
            POS_HUM_LO: begin
                humid_word_next = {humid_word_reg[WORD_W-1:BYTE_W], in_byte_reg};
                crc_next        = crc8_add(crc_base, in_byte_reg);
            end
            POS_HUM_CRC: begin
                pos_next = POS_TEMP_HI;
                crc_next = CRC_INIT;
            end
            default: begin
                pos_next = POS_TEMP_HI;
            end
        endcase
    end

    // conversion of the finished frame
    always_comb begin
        temp_prod  = 24'(TEMP_SCALE) * 24'(temp_word_reg);
        humid_prod = 23'(HUMID_SCALE) * 23'(humid_word_reg);
        temp_full  = $signed({2'b00, temp_prod[23:8]}) - TEMP_BASE_Q8
                   - $signed({{2{offset_reg[WORD_W-1]}}, offset_reg});

        err_next = ERR_NONE;
        if (!temp_good_reg) begin
            err_next = err_next | ERR_TEMP;
        end
        if (crc_reg != in_byte_reg) begin
            err_next = err_next | ERR_HUMID;
        end
        read_ok_next = (err_next == ERR_NONE);

        if (!read_ok_next) begin
            temp_q8_next = '0;
        end else if (temp_full > TEMP_MAX_Q8) begin
            temp_q8_next = TEMP_MAX_Q8[TEMP_W-1:0];
        end else if (temp_full < TEMP_MIN_Q8) begin
            temp_q8_next = TEMP_MIN_Q8[TEMP_W-1:0];
        end else begin
            temp_q8_next = temp_full[TEMP_W-1:0];
        end

        humid_q8_next = read_ok_next ? humid_prod[22:8] : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_reg     <= TEMP_OFFSET_RESET;
            in_valid_reg   <= 1'b0;
            pos_reg        <= POS_TEMP_HI;
            crc_reg        <= CRC_INIT;
            temp_word_reg  <= '0;
            humid_word_reg <= '0;
            temp_good_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                offset_reg <= cfg_wr_data;
            end
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                pos_reg        <= pos_next;
                crc_reg        <= crc_next;
                temp_word_reg  <= temp_word_next;
                humid_word_reg <= humid_word_next;
                temp_good_reg  <= temp_good_next;
            end
            if (advance && emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg  <= s_rx_byte;
            in_first_reg <= s_first_byte;
        end
        if (advance && emit) begin
            read_ok_reg  <= read_ok_next;
            err_reg      <= err_next;
            temp_q8_reg  <= temp_q8_next;
            humid_q8_reg <= humid_q8_next;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_read_ok        = read_ok_reg;
    assign m_error_code     = err_reg;
    assign m_temperature_q8 = temp_q8_reg;
    assign m_humidity_q8    = humid_q8_reg;

`ifndef NO_ASSERTIONS
    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= POS_HUM_CRC)
        else $error("frame position out of range");

    a_ok_matches_err: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_read_ok == (m_error_code == ERR_NONE)))
        else $error("read_ok disagrees with error_code");

    a_bad_read_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_read_ok) |-> (m_temperature_q8 == '0 && m_humidity_q8 == '0))
        else $error("readings not cleared on crc failure");

    a_humid_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_humidity_q8 <= HUMID_MAX_Q8))
        else $error("humidity above full scale");

    a_emit_after_sixth: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && emit) |=> (m_valid && pos_reg == POS_TEMP_HI))
        else $error("sixth word did not produce a result");
`endif

endmodule

// ===== verif/humidity_temp_frame_decoder_test.sv =====
// self-checking testbench for the humidity/temperature frame decoder
`timescale 1ns / 1ps

module humidity_temp_frame_decoder_test;
    import htfd_pkg::*;

    localparam int QUIET_LIMIT   = 1000;
    localparam int RANDOM_WORDS  = 1950;
    localparam int RANDOM_PHASES = 5;

    typedef struct packed {
        logic                      ok;
        logic [ERR_W-1:0]          err;
        logic signed [TEMP_W-1:0]  temp;
        logic [HUMID_W-1:0]        humid;
    } reading_t;

    logic                      aclk = 1'b0;
    logic                      aresetn = 1'b0;
    logic                      cfg_wr_en = 1'b0;
    logic signed [WORD_W-1:0]  cfg_wr_data = '0;
    logic                      s_valid = 1'b0;
    logic                      s_ready;
    logic [BYTE_W-1:0]         s_rx_byte = '0;
    logic                      s_first_byte = 1'b0;
    logic                      m_valid;
    logic                      m_ready = 1'b0;
    logic                      m_read_ok;
    logic [ERR_W-1:0]          m_error_code;
    logic signed [TEMP_W-1:0]  m_temperature_q8;
    logic [HUMID_W-1:0]        m_humidity_q8;

    logic [POS_W-1:0]          frame_pos = POS_TEMP_HI;
    logic [BYTE_W-1:0]         crc_acc = CRC_INIT;
    logic [WORD_W-1:0]         raw_temp = '0;
    logic [WORD_W-1:0]         raw_humid = '0;
    logic                      temp_crc_ok = 1'b0;
    logic signed [WORD_W-1:0]  temp_offset = TEMP_OFFSET_RESET;

    reading_t                  pending_readings[$];
    int                        fail_count = 0;
    int                        sent_words = 0;
    int                        quiet_cycles = 0;
    logic                      idle_on = 1'b1;

    humidity_temp_frame_decoder i_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_rx_byte        (s_rx_byte),
        .s_first_byte     (s_first_byte),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_read_ok        (m_read_ok),
        .m_error_code     (m_error_code),
        .m_temperature_q8 (m_temperature_q8),
        .m_humidity_q8    (m_humidity_q8)
    );

    always #5 aclk = ~aclk;

    function automatic logic [BYTE_W-1:0] crc8_step(logic [BYTE_W-1:0] crc,
                                                    logic [BYTE_W-1:0] d);
        logic [BYTE_W-1:0] c;
        logic              fb;
        c = crc;
        for (int i = BYTE_W - 1; i >= 0; i--) begin
            fb = c[BYTE_W-1] ^ d[i];
            c = {c[BYTE_W-2:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
        end
        return c;
    endfunction

    function automatic logic [BYTE_W-1:0] word_crc(logic [WORD_W-1:0] w);
        return crc8_step(crc8_step(CRC_INIT, w[15:8]), w[7:0]);
    endfunction

    function automatic void decode_word(logic [BYTE_W-1:0] b, logic f);
        logic [POS_W-1:0] pos;
        logic             hum_ok;
        logic [ERR_W-1:0] err;
        int               t;
        int               h;
        reading_t         r;
        pos = f ? POS_TEMP_HI : frame_pos;
        if (pos > POS_HUM_CRC) begin
            pos = POS_TEMP_HI;
        end
        if (pos == POS_TEMP_HI || pos == POS_HUM_HI) begin
            crc_acc = CRC_INIT;
        end
        case (pos)
            POS_TEMP_HI: begin
                raw_temp[15:8] = b;
                crc_acc = crc8_step(crc_acc, b);
            end
            POS_TEMP_LO: begin
                raw_temp[7:0] = b;
                crc_acc = crc8_step(crc_acc, b);
            end
            POS_TEMP_CRC: begin
                temp_crc_ok = (crc_acc == b);
                crc_acc = CRC_INIT;
            end
            POS_HUM_HI: begin
                raw_humid[15:8] = b;
                crc_acc = crc8_step(crc_acc, b);
            end
            POS_HUM_LO: begin
                raw_humid[7:0] = b;
                crc_acc = crc8_step(crc_acc, b);
            end
            default: ;
        endcase
        if (pos != POS_HUM_CRC) begin
            frame_pos = pos + 1'b1;
            return;
        end
        hum_ok = (crc_acc == b);
        err = (temp_crc_ok ? ERR_NONE : ERR_TEMP) | (hum_ok ? ERR_NONE : ERR_HUMID);
        t = 0;
        h = 0;
        if (err == ERR_NONE) begin
            t = ((int'(TEMP_SCALE) * int'(raw_temp)) >> 8) - int'(TEMP_BASE_Q8)
                - int'(temp_offset);
            if (t > int'(TEMP_MAX_Q8)) begin
                t = int'(TEMP_MAX_Q8);
            end
            if (t < int'(TEMP_MIN_Q8)) begin
                t = int'(TEMP_MIN_Q8);
            end
            h = (int'(HUMID_SCALE) * int'(raw_humid)) >> 8;
        end
        r.ok    = (err == ERR_NONE);
        r.err   = err;
        r.temp  = t[TEMP_W-1:0];
        r.humid = h[HUMID_W-1:0];
        pending_readings.push_back(r);
        frame_pos = POS_TEMP_HI;
        crc_acc = CRC_INIT;
    endfunction

    task automatic send_word(logic [BYTE_W-1:0] b, logic f);
        int gap;
        gap = idle_on ? $urandom_range(0, 14) : 0;
        @(negedge aclk);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid      <= 1'b1;
        s_rx_byte    <= b;
        s_first_byte <= f;
        do @(posedge aclk); while (!(s_valid && s_ready));
        decode_word(b, f);
        sent_words++;
    endtask

    task automatic send_frame(logic [WORD_W-1:0] t, logic [WORD_W-1:0] h,
                              logic bad_t, logic bad_h, logic mark);
        logic [BYTE_W-1:0] ct;
        logic [BYTE_W-1:0] ch;
        ct = word_crc(t) ^ (bad_t ? BYTE_W'($urandom_range(1, 255)) : 8'h00);
        ch = word_crc(h) ^ (bad_h ? BYTE_W'($urandom_range(1, 255)) : 8'h00);
        send_word(t[15:8], mark);
        send_word(t[7:0], 1'b0);
        send_word(ct, 1'b0);
        send_word(h[15:8], 1'b0);
        send_word(h[7:0], 1'b0);
        send_word(ch, 1'b0);
    endtask

    task automatic wait_idle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_readings.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_offset(logic signed [WORD_W-1:0] v);
        wait_idle();
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        temp_offset = v;
    endtask

    task automatic test_reset_offset();
        send_frame(WORD_W'($urandom), WORD_W'($urandom), 1'b0, 1'b0, 1'b1);
    endtask

    task automatic test_crc_errors();
        // unmarked frame relies on the wrap after the sixth word
        send_frame(WORD_W'($urandom), WORD_W'($urandom), 1'b1, 1'b0, 1'b0);
    endtask

    task automatic test_resync();
        send_word(8'hA5, 1'b1);
        send_word(8'h3C, 1'b0);
        send_frame(WORD_W'($urandom), WORD_W'($urandom), 1'b0, 1'b1, 1'b1);
    endtask

    task automatic test_offset_extremes();
        // saturates high
        set_offset(-16'sd32768);
        send_frame(16'hFFFF, 16'h0000, 1'b0, 1'b0, 1'b1);
        set_offset(16'sd32767);
        send_frame(16'h0000, 16'hFFFF, 1'b0, 1'b0, 1'b0);
    endtask

    task automatic test_random();
        int                start;
        int                kind;
        int                n;
        logic [WORD_W-1:0] t;
        logic [WORD_W-1:0] h;
        logic [1:0]        bad;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0: set_offset(16'sd32767);
                1: set_offset(-16'sd32768);
                2: set_offset(WORD_W'($urandom));
                3: set_offset(16'sd0);
                default: set_offset(TEMP_OFFSET_RESET);
            endcase
            start = sent_words;
            while (sent_words - start < RANDOM_WORDS / RANDOM_PHASES) begin
                idle_on = ($urandom_range(0, 3) != 0);
                kind = $urandom_range(0, 99);
                if (kind < 80) begin
                    t = ($urandom_range(0, 9) == 0) ? {WORD_W{$urandom_range(0, 1) == 1}}
                                                    : WORD_W'($urandom);
                    h = ($urandom_range(0, 9) == 0) ? {WORD_W{$urandom_range(0, 1) == 1}}
                                                    : WORD_W'($urandom);
                    bad = ($urandom_range(0, 99) < 85) ? 2'b00 : 2'($urandom_range(1, 3));
                    send_frame(t, h, bad[0], bad[1], $urandom_range(0, 3) != 0);
                end else if (kind < 90) begin
                    // truncated frame
                    n = $urandom_range(1, 5);
                    send_word(BYTE_W'($urandom), 1'b1);
                    for (int i = 1; i < n; i++) begin
                        send_word(BYTE_W'($urandom), 1'b0);
                    end
                end else begin
                    n = $urandom_range(1, 8);
                    for (int i = 0; i < n; i++) begin
                        send_word(BYTE_W'($urandom), 1'($urandom_range(0, 1)));
                    end
                end
            end
        end
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_reset_offset();
        test_crc_errors();
        test_resync();
        test_offset_extremes();
        test_random();
        wait_idle();
        repeat (8) @(posedge aclk);
        if (pending_readings.size() != 0) begin
            $error("%0d readings never arrived", pending_readings.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        int stall;
        wait (aresetn === 1'b1);
        forever begin
            stall = idle_on ? $urandom_range(0, 14) : 0;
            @(negedge aclk);
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
        end
    end

    always @(posedge aclk) begin
        reading_t r;
        if (aresetn && m_valid && m_ready) begin
            if (pending_readings.size() == 0) begin
                $error("reading with no word pending");
                fail_count++;
            end else begin
                r = pending_readings.pop_front();
                if (m_read_ok !== r.ok) begin
                    $error("read_ok expected %0d got %0d", r.ok, m_read_ok);
                    fail_count++;
                end
                if (m_error_code !== r.err) begin
                    $error("error_code expected %0d got %0d", r.err, m_error_code);
                    fail_count++;
                end
                if (m_temperature_q8 !== r.temp) begin
                    $error("temperature_q8 expected %0d got %0d", r.temp, m_temperature_q8);
                    fail_count++;
                end
                if (m_humidity_q8 !== r.humid) begin
                    $error("humidity_q8 expected %0d got %0d", r.humid, m_humidity_q8);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

endmodule
